// File: hdl/sqltl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltl_pkg
// Shared types, token codes, word tables and byte class helpers for the
// SQL token lexer.
// ----------------------------------------------------------------------------
package sqltl_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int NUM_WORDS   = 6;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] KIND_EOF        = 4'd0;
    localparam logic [3:0] KIND_INVALID    = 4'd1;
    localparam logic [3:0] KIND_IDENTIFIER = 4'd2;
    localparam logic [3:0] KIND_COMMA      = 4'd3;
    localparam logic [3:0] KIND_SEMICOLON  = 4'd4;
    localparam logic [3:0] KIND_STAR       = 4'd5;
    localparam logic [3:0] KIND_LPAREN     = 4'd6;
    localparam logic [3:0] KIND_RPAREN     = 4'd7;
    localparam logic [3:0] KIND_SELECT     = 4'd8;
    localparam logic [3:0] KIND_TABLE      = 4'd9;
    localparam logic [3:0] KIND_CREATE     = 4'd10;
    localparam logic [3:0] KIND_FROM       = 4'd11;
    localparam logic [3:0] KIND_TABLES     = 4'd12;
    localparam logic [3:0] KIND_DBINFO     = 4'd13;

    localparam logic [NUM_WORDS-1:0] CAND_KEYWORDS = 6'b001111;
    localparam logic [NUM_WORDS-1:0] CAND_COMMANDS = 6'b110000;
    localparam int FIRST_COMMAND = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
        '{"s", "e", "l", "e", "c", "t", 8'h00, 8'h00},
        '{"t", "a", "b", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"c", "r", "e", "a", "t", "e", 8'h00, 8'h00},
        '{"f", "r", "o", "m", 8'h00, 8'h00, 8'h00, 8'h00},
        '{".", "t", "a", "b", "l", "e", "s", 8'h00},
        '{".", "d", "b", "i", "n", "f", "o", 8'h00}
    };

    localparam logic [FIELD_BITS-1:0] WORD_LEN [NUM_WORDS] = '{
        16'd6, 16'd5, 16'd6, 16'd4, 16'd7, 16'd7
    };

    localparam logic [3:0] WORD_KIND [NUM_WORDS] = '{
        KIND_SELECT, KIND_TABLE, KIND_CREATE, KIND_FROM, KIND_TABLES, KIND_DBINFO
    };

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_CMD
    } t_mode;

    typedef struct packed {
        logic [3:0]            kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_lex_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic logic [FIELD_BITS-1:0] clip_field(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[FIELD_BITS-1:0];
    endfunction

    // keep candidates whose char at index k equals c
    function automatic logic [NUM_WORDS-1:0] narrow(input logic [NUM_WORDS-1:0] cand,
                                                    input logic [FIELD_BITS-1:0] k,
                                                    input logic [7:0] c);
        logic [NUM_WORDS-1:0] keep;
        logic [7:0]           got;
        keep = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            got = (i >= FIRST_COMMAND && k == 16'd1) ? c : lower_byte(c);
            if (cand[i] && k < WORD_LEN[i] && got == WORD_TEXT[i][k[2:0]]) begin
                keep[i] = 1'b1;
            end
        end
        return keep;
    endfunction

endpackage

// File: hdl/sqltl_lex.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltl_lex
// Scanner state and per-byte token decode. Produces up to two tokens for
// each consumed byte.
// ----------------------------------------------------------------------------
module sqltl_lex (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    output sqltl_pkg::t_lex_out  o_out
);

    sqltl_pkg::t_mode                          r_mode, n_mode;
    logic [sqltl_pkg::OFFSET_BITS-1:0]         r_pos, n_pos;
    logic [sqltl_pkg::OFFSET_BITS-1:0]         r_begin, n_begin;
    logic [sqltl_pkg::NUM_WORDS-1:0]           r_cand, n_cand;
    logic [sqltl_pkg::FIELD_BITS-1:0]          r_count, n_count;

    logic [sqltl_pkg::OFFSET_BITS-1:0]         pos_inc;
    logic [3:0]                                close_kind;
    logic                                      more;
    sqltl_pkg::t_token                         tok_a, tok_b;
    logic [1:0]                                n_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sqltl_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_cand  <= '0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_cand  <= n_cand;
            r_count <= n_count;
        end
    end

    always_comb begin
        pos_inc = (r_pos == '1) ? r_pos : r_pos + sqltl_pkg::OFFSET_BITS'(1);

        close_kind = (r_mode == sqltl_pkg::MODE_IDENT) ? sqltl_pkg::KIND_IDENTIFIER
                                                       : sqltl_pkg::KIND_INVALID;
        for (int i = 0; i < sqltl_pkg::NUM_WORDS; i++) begin
            if (r_cand[i] && r_count == sqltl_pkg::WORD_LEN[i]) begin
                close_kind = sqltl_pkg::WORD_KIND[i];
            end
        end

        more = (r_mode == sqltl_pkg::MODE_IDENT) ?
               (sqltl_pkg::is_letter(i_byte) || sqltl_pkg::is_decimal(i_byte)) :
               sqltl_pkg::is_letter(i_byte);

        n_mode  = r_mode;
        n_pos   = r_pos;
        n_begin = r_begin;
        n_cand  = r_cand;
        n_count = r_count;
        n_tok   = 2'd0;
        tok_a   = '0;
        tok_b   = '0;

        if (i_valid) begin
            if (r_mode != sqltl_pkg::MODE_IDLE && more) begin
                n_cand  = sqltl_pkg::narrow(r_cand, r_count, i_byte);
                n_count = (r_count == '1) ? r_count : r_count + sqltl_pkg::FIELD_BITS'(1);
                n_pos   = pos_inc;
            end else begin
                if (r_mode != sqltl_pkg::MODE_IDLE) begin
                    tok_a.kind   = close_kind;
                    tok_a.start  = sqltl_pkg::clip_field(r_begin);
                    tok_a.length = r_count;
                    n_tok        = 2'd1;
                    n_cand       = '0;
                end
                n_mode = sqltl_pkg::MODE_IDLE;

                tok_b = '0;
                if (i_byte == sqltl_pkg::CH_NUL) begin
                    tok_b.kind   = sqltl_pkg::KIND_EOF;
                    tok_b.start  = sqltl_pkg::clip_field(r_pos);
                    tok_b.length = '0;
                    n_tok        = n_tok + 2'd1;
                    n_pos        = '0;
                end else if (sqltl_pkg::is_blank(i_byte)) begin
                    n_pos = pos_inc;
                end else if (sqltl_pkg::is_letter(i_byte) || i_byte == sqltl_pkg::CH_DOT) begin
                    n_mode  = (i_byte == sqltl_pkg::CH_DOT) ? sqltl_pkg::MODE_CMD
                                                           : sqltl_pkg::MODE_IDENT;
                    n_begin = r_pos;
                    n_count = 16'd1;
                    n_cand  = sqltl_pkg::narrow((i_byte == sqltl_pkg::CH_DOT) ?
                                                sqltl_pkg::CAND_COMMANDS :
                                                sqltl_pkg::CAND_KEYWORDS,
                                                16'd0, i_byte);
                    n_pos   = pos_inc;
                end else begin
                    case (i_byte)
                        sqltl_pkg::CH_COMMA:  tok_b.kind = sqltl_pkg::KIND_COMMA;
                        sqltl_pkg::CH_SEMI:   tok_b.kind = sqltl_pkg::KIND_SEMICOLON;
                        sqltl_pkg::CH_STAR:   tok_b.kind = sqltl_pkg::KIND_STAR;
                        sqltl_pkg::CH_LPAREN: tok_b.kind = sqltl_pkg::KIND_LPAREN;
                        sqltl_pkg::CH_RPAREN: tok_b.kind = sqltl_pkg::KIND_RPAREN;
                        default:              tok_b.kind = sqltl_pkg::KIND_INVALID;
                    endcase
                    tok_b.start  = sqltl_pkg::clip_field(r_pos);
                    tok_b.length = 16'd1;
                    n_tok        = n_tok + 2'd1;
                    n_pos        = pos_inc;
                end
            end
        end

        // pack: the closing token (if any) goes first
        o_out.count = n_tok;
        if (r_mode != sqltl_pkg::MODE_IDLE && n_tok != 2'd0 && !more) begin
            o_out.tok0 = tok_a;
            o_out.tok1 = tok_b;
        end else begin
            o_out.tok0 = tok_b;
            o_out.tok1 = tok_a;
        end
        o_out.tok0.last = (n_tok == 2'd1);
        o_out.tok1.last = 1'b1;
    end

`ifndef SYNTH
    a_idle_no_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sqltl_pkg::MODE_IDLE) |-> (r_cand == '0))
        else $error("candidates set while idle");
    a_ident_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sqltl_pkg::MODE_IDENT) |-> ((r_cand & sqltl_pkg::CAND_COMMANDS) == '0))
        else $error("command candidate in identifier");
    a_cmd_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sqltl_pkg::MODE_CMD) |-> ((r_cand & sqltl_pkg::CAND_KEYWORDS) == '0))
        else $error("keyword candidate in command");
`endif

endmodule

// File: hdl/sqltl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltl_fifo
// Small token queue: takes up to two tokens per cycle, hands out one word
// per cycle on the output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module sqltl_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sqltl_pkg::t_lex_out  i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sqltl_pkg::t_token    o_tok
);

    sqltl_pkg::t_token                        r_mem [sqltl_pkg::FIFO_DEPTH];
    logic [sqltl_pkg::FIFO_PTR_BITS-1:0]      r_wr_ptr, n_wr_ptr;
    logic [sqltl_pkg::FIFO_PTR_BITS-1:0]      r_rd_ptr, n_rd_ptr;
    logic [sqltl_pkg::FIFO_CNT_BITS-1:0]      r_count, n_count;
    logic                                     pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= sqltl_pkg::FIFO_CNT_BITS'(sqltl_pkg::FIFO_DEPTH - 2));
    assign o_tok   = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + sqltl_pkg::FIFO_PTR_BITS'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + sqltl_pkg::FIFO_PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count + sqltl_pkg::FIFO_CNT_BITS'(i_push.count)
                   - sqltl_pkg::FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + sqltl_pkg::FIFO_PTR_BITS'(1)] <= i_push.tok1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sqltl_pkg::FIFO_CNT_BITS'(sqltl_pkg::FIFO_DEPTH))
        else $error("token queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");
    a_push_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2) |-> (!i_push.tok0.last && i_push.tok1.last))
        else $error("bad last flags on double push");
`endif

endmodule

// File: hdl/sql_token_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_lexer_core
// SQL keyword/command lexer: one source byte per word in, one token per
// word out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while it does not stall. A byte is
// held in an input register, decoded from it against the scanner state once
// the queue has room, and its tokens land in a four-entry queue that drives
// the output. A byte that both closes a token and makes its own (or EOF)
// writes two queue entries but the output drains one per clock while not
// stalled; input stalls only when the queue holds more than two tokens. A
// multi-byte token appears when the byte after it arrives. Offsets saturate
// at 65535 and the position returns to zero after EOF.
module sql_token_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic                 r_in_valid, n_in_valid;
    logic [7:0]           r_in_byte;
    logic                 room;
    logic                 consume;
    logic                 accept;
    sqltl_pkg::t_lex_out  lex_out;
    sqltl_pkg::t_token    out_tok;

    assign consume = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = accept ? 1'b1 : (consume ? 1'b0 : r_in_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
        end
    end

    sqltl_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (consume),
        .i_byte  (r_in_byte),
        .o_out   (lex_out)
    );

    sqltl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lex_out),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (out_tok)
    );

    assign o_token_kind   = out_tok.kind;
    assign o_token_start  = out_tok.start;
    assign o_token_length = out_tok.length;
    assign o_last_of_run  = out_tok.last;

endmodule

// File: bench/sqltl_token_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltl_token_check
// Watches both channels of the SQL token lexer. Every accepted source byte is
// run through an independent model of the scanner, which queues the tokens it
// should produce; every accepted token is compared field by field against the
// oldest queued one. Mismatch and pending counts go to the bench top.
// ----------------------------------------------------------------------------
module sqltl_token_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_byte,
    input  logic        i_tok_valid,
    input  logic        i_tok_stall,
    input  logic [3:0]  i_kind,
    input  logic [15:0] i_start,
    input  logic [15:0] i_length,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);

    sqltl_pkg::t_mode   mode;
    logic [15:0]        pos;
    logic [15:0]        run_start;
    logic [15:0]        run_len;
    logic [5:0]         live;
    sqltl_pkg::t_token  expected_tokens [$];
    int                 errors = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int word_size(input int i);
        case (i)
            0: return 6;
            1: return 5;
            2: return 6;
            3: return 4;
            default: return 7;
        endcase
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // words still matched after char k of the open token
    function automatic logic [5:0] keep_words(input logic [5:0] cand,
                                              input logic [15:0] k,
                                              input logic [7:0] c);
        logic [5:0]  keep;
        logic [55:0] txt;
        logic [7:0]  got;
        int          n;
        keep = '0;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0: txt = "select";
                1: txt = "table";
                2: txt = "create";
                3: txt = "from";
                4: txt = ".tables";
                default: txt = ".dbinfo";
            endcase
            n = word_size(i);
            if (i >= 4 && k == 16'd1) begin
                got = c;
            end else begin
                got = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            end
            if (cand[i] && int'(k) < n) begin
                if (txt[8 * (n - 1 - int'(k)) +: 8] == got) begin
                    keep[i] = 1'b1;
                end
            end
        end
        return keep;
    endfunction

    task automatic step_pos();
        if (pos != 16'hFFFF) begin
            pos = pos + 16'd1;
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        sqltl_pkg::t_token found [2];
        int                n;
        logic              keep_on;
        logic [3:0]        kind;
        n = 0;
        keep_on = 1'b0;
        if (mode != sqltl_pkg::MODE_IDLE) begin
            keep_on = (mode == sqltl_pkg::MODE_IDENT) ? (name_char(c) || digit(c))
                                                      : name_char(c);
            if (keep_on) begin
                live = keep_words(live, run_len, c);
                if (run_len != 16'hFFFF) begin
                    run_len = run_len + 16'd1;
                end
                step_pos();
            end else begin
                kind = (mode == sqltl_pkg::MODE_IDENT) ? sqltl_pkg::KIND_IDENTIFIER
                                                       : sqltl_pkg::KIND_INVALID;
                for (int i = 0; i < 6; i++) begin
                    if (live[i] && int'(run_len) == word_size(i)) begin
                        kind = 4'(sqltl_pkg::KIND_SELECT + i);
                    end
                end
                found[n] = '{kind, run_start, run_len, 1'b0};
                n++;
                mode = sqltl_pkg::MODE_IDLE;
                live = '0;
            end
        end
        if (!keep_on) begin
            if (c == sqltl_pkg::CH_NUL) begin
                found[n] = '{sqltl_pkg::KIND_EOF, pos, 16'd0, 1'b0};
                n++;
                pos = '0;
            end else if (c == sqltl_pkg::CH_SPACE || c == sqltl_pkg::CH_TAB ||
                         c == sqltl_pkg::CH_LF || c == sqltl_pkg::CH_CR) begin
                step_pos();
            end else if (name_char(c) || c == sqltl_pkg::CH_DOT) begin
                mode = (c == sqltl_pkg::CH_DOT) ? sqltl_pkg::MODE_CMD : sqltl_pkg::MODE_IDENT;
                run_start = pos;
                run_len = 16'd1;
                live = keep_words((c == sqltl_pkg::CH_DOT) ? sqltl_pkg::CAND_COMMANDS
                                                           : sqltl_pkg::CAND_KEYWORDS,
                                  16'd0, c);
                step_pos();
            end else begin
                case (c)
                    sqltl_pkg::CH_COMMA:  kind = sqltl_pkg::KIND_COMMA;
                    sqltl_pkg::CH_SEMI:   kind = sqltl_pkg::KIND_SEMICOLON;
                    sqltl_pkg::CH_STAR:   kind = sqltl_pkg::KIND_STAR;
                    sqltl_pkg::CH_LPAREN: kind = sqltl_pkg::KIND_LPAREN;
                    sqltl_pkg::CH_RPAREN: kind = sqltl_pkg::KIND_RPAREN;
                    default:              kind = sqltl_pkg::KIND_INVALID;
                endcase
                found[n] = '{kind, pos, 16'd1, 1'b0};
                n++;
                step_pos();
            end
        end
        for (int j = 0; j < n; j++) begin
            found[j].last = (j == n - 1);
            expected_tokens.push_back(found[j]);
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("token mismatch at %0t: %0s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic check_token();
        sqltl_pkg::t_token want;
        if (expected_tokens.size() == 0) begin
            report("unexpected token, kind", i_kind, -1);
        end else begin
            want = expected_tokens.pop_front();
            if (i_kind != want.kind) begin
                report("kind", i_kind, want.kind);
            end
            if (i_start != want.start) begin
                report("start", i_start, want.start);
            end
            if (i_length != want.length) begin
                report("length", i_length, want.length);
            end
            if (i_last != want.last) begin
                report("last_of_run", i_last, want.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = sqltl_pkg::MODE_IDLE;
            pos = '0;
            run_start = '0;
            run_len = '0;
            live = '0;
            expected_tokens.delete();
        end else begin
            if (i_tok_valid && !i_tok_stall) begin
                check_token();
            end
            if (i_byte_valid && !i_byte_stall) begin
                lex_byte(i_byte);
            end
        end
        o_errors  <= errors;
        o_pending <= expected_tokens.size();
    end

endmodule

// File: bench/tb_sql_token_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_token_lexer_core
// Feeds the SQL token lexer a directed string covering the punctuation kinds,
// FROM, .dbinfo and odd bytes, one long identifier, then random SQL-like text
// mixed with noise, under random idle and stall bursts.
// The token checker does the prediction; this top only drives and judges.
// ----------------------------------------------------------------------------
module tb_sql_token_lexer_core;

    localparam int LIMIT        = 2_000_000;
    localparam int RANDOM_WORDS = 1220;
    localparam int QUIET_TAIL   = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    int errors;
    int pending;
    int cycles = 0;
    int sent = 0;
    int stall_hold = 0;
    logic quiet = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sql_token_lexer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    sqltl_token_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_valid),
        .i_byte_stall (o_stall),
        .i_byte       (i_text_byte),
        .i_tok_valid  (o_valid),
        .i_tok_stall  (i_stall),
        .i_kind       (o_token_kind),
        .i_start      (o_token_start),
        .i_length     (o_token_length),
        .i_last       (o_last_of_run),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // random output stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        i_valid <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sent++;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] tail_byte();
        case ($urandom_range(0, 3))
            0: return 8'("0" + $urandom_range(0, 9));
            1: return 8'("_");
            default: return mix_case(8'("a" + $urandom_range(0, 25)));
        endcase
    endfunction

    task automatic send_piece();
        int         sel;
        int         w;
        int         n;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            // keyword or dot command, sometimes cut short or run on
            w = (sel < 30) ? $urandom_range(0, 3) : $urandom_range(4, 5);
            n = int'(sqltl_pkg::WORD_LEN[w]);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, n);
            end
            for (int k = 0; k < n; k++) begin
                c = sqltl_pkg::WORD_TEXT[w][k];
                if (w >= 4 && k == 1) begin
                    send_byte(($urandom_range(0, 4) == 0) ? (c & 8'hDF) : c);
                end else begin
                    send_byte(mix_case(c));
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                send_byte(tail_byte());
            end
        end else if (sel < 60) begin
            send_byte($urandom_range(0, 3) == 0 ? 8'("_")
                                                : mix_case(8'("a" + $urandom_range(0, 25))));
            repeat ($urandom_range(0, 7)) send_byte(tail_byte());
        end else if (sel < 75) begin
            case ($urandom_range(0, 4))
                0: send_byte(sqltl_pkg::CH_COMMA);
                1: send_byte(sqltl_pkg::CH_SEMI);
                2: send_byte(sqltl_pkg::CH_STAR);
                3: send_byte(sqltl_pkg::CH_LPAREN);
                default: send_byte(sqltl_pkg::CH_RPAREN);
            endcase
        end else if (sel < 88) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: send_byte(sqltl_pkg::CH_TAB);
                    1: send_byte(sqltl_pkg::CH_LF);
                    2: send_byte(sqltl_pkg::CH_CR);
                    default: send_byte(sqltl_pkg::CH_SPACE);
                endcase
            end
        end else if (sel < 97) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(sqltl_pkg::CH_NUL);
        end
    endtask

    initial begin
        int base;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_str("From(*),;\t.dbInfo5\r\n_x9 .Tab");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(sqltl_pkg::CH_NUL);

        // one long identifier
        send_byte("q");
        repeat (39) send_byte(tail_byte());
        send_byte(sqltl_pkg::CH_SPACE);
        send_byte(sqltl_pkg::CH_COMMA);
        send_byte(sqltl_pkg::CH_NUL);

        base = sent;
        while (sent < base + RANDOM_WORDS) begin
            if (sent >= base + RANDOM_WORDS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            send_piece();
        end
        send_byte(sqltl_pkg::CH_NUL);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
